// File: sv/matrix_keypad_debounce_latch_defines.svh
// ----------------------------------------------------------------------------
// Keypad debounce latch assertion macros
// Shared concurrent assertion wrappers for the keypad reader modules.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_DEBOUNCE_LATCH_DEFINES_SVH
`define MATRIX_KEYPAD_DEBOUNCE_LATCH_DEFINES_SVH

// Check a property on every rising clock edge, quiet while reset is high.
`define KPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define KPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/kpd_pkg.sv
// ----------------------------------------------------------------------------
// Keypad debounce latch package
// Widths, codes and the key-to-ASCII map shared by the keypad reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpd_pkg;

   localparam int KEY_SLOTS   = 16;
   localparam int KEY_W       = 5;
   localparam int CHAR_W      = 7;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [KEY_W-1:0]      NO_KEY         = 5'd16;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [CHAR_W-1:0]     NO_CHAR        = 7'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCANNER_ENABLED = 2'd0,
      CSR_DEBOUNCE_MS     = 2'd1
   } csr_index_type;

   // Fixed legend of the 4x4 pad, index row*4+column.
   function automatic logic [CHAR_W-1:0] key_ascii(input logic [3:0] idx);
      logic [CHAR_W-1:0] ch;
      case (idx)
         4'd0:    ch = 7'h44; // D
         4'd1:    ch = 7'h43; // C
         4'd2:    ch = 7'h42; // B
         4'd3:    ch = 7'h41; // A
         4'd4:    ch = 7'h23; // #
         4'd5:    ch = 7'h39; // 9
         4'd6:    ch = 7'h36; // 6
         4'd7:    ch = 7'h33; // 3
         4'd8:    ch = 7'h30; // 0
         4'd9:    ch = 7'h38; // 8
         4'd10:   ch = 7'h35; // 5
         4'd11:   ch = 7'h32; // 2
         4'd12:   ch = 7'h2A; // *
         4'd13:   ch = 7'h37; // 7
         4'd14:   ch = 7'h34; // 4
         4'd15:   ch = 7'h31; // 1
         default: ch = NO_CHAR;
      endcase
      return ch;
   endfunction

endpackage

// File: sv/matrix_keypad_debounce_latch.sv
// ----------------------------------------------------------------------------
// Matrix keypad debounce latch
// Each request is one poll of the key matrix: a snapshot of pressed keys and
// its millisecond time stamp. The lowest pressed key wins; a reading must stay
// unchanged for debounce_ms before it counts, and a stable key is reported
// once as ASCII (zero otherwise) until a stable release clears the latch.
// Exactly one response follows every request, by way of the input register
// and then the response register, and one poll is taken every cycle while
// the response side does not stall: these two registers surround the
// encoder, the timer compare and the legend lookup, so a new request is
// taken while a finished response still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_keypad_debounce_latch
   import kpd_pkg::*;
#(
   parameter int ROWS    = 4,
   parameter int COLUMNS = 4
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KEY_SLOTS-1:0]   req_keys_pressed,
   input  logic [TIME_W-1:0]      req_now_ms,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_W-1:0]      rsp_key_char
);

   logic                  scanner_enabled_ff, scanner_enabled_in;
   logic [DEBOUNCE_W-1:0] debounce_ms_ff, debounce_ms_in;

   logic                  in_valid_ff, in_valid_in;
   logic [KEY_SLOTS-1:0]  in_keys_ff, in_keys_in;
   logic [TIME_W-1:0]     in_now_ff, in_now_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_key_char_ff, rsp_key_char_in;

   logic                  advance;
   logic                  accept;
   logic [KEY_W-1:0]      raw_key;
   logic [CHAR_W-1:0]     key_char;

   // advance the held request whenever the response slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      scanner_enabled_in = scanner_enabled_ff;
      debounce_ms_in     = debounce_ms_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SCANNER_ENABLED: scanner_enabled_in = csr_write_data[0];
            CSR_DEBOUNCE_MS:     debounce_ms_in     = csr_write_data[DEBOUNCE_W-1:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_keys_in  = in_keys_ff;
      in_now_in   = in_now_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_keys_in  = req_keys_pressed;
         in_now_in   = req_now_ms;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in    = advance || (rsp_valid_ff && rsp_stall);
      rsp_key_char_in = advance ? key_char : rsp_key_char_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanner_enabled_ff <= 1'b0;
         debounce_ms_ff     <= DEBOUNCE_RESET;
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         scanner_enabled_ff <= scanner_enabled_in;
         debounce_ms_ff     <= debounce_ms_in;
         in_valid_ff        <= in_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_keys_ff      <= in_keys_in;
      in_now_ff       <= in_now_in;
      rsp_key_char_ff <= rsp_key_char_in;
   end

   kpd_encode #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_encode (
      .scanner_enabled (scanner_enabled_ff),
      .keys_pressed    (in_keys_ff),
      .raw_key         (raw_key)
   );

   kpd_debounce u_debounce (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .raw_key     (raw_key),
      .now_ms      (in_now_ff),
      .debounce_ms (debounce_ms_ff),
      .key_char    (key_char)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_char = rsp_key_char_ff;

endmodule

// File: sv/kpd_encode.sv
// ----------------------------------------------------------------------------
// Keypad priority encoder
// Picks the lowest pressed key inside the matrix, or no key when disabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kpd_encode
   import kpd_pkg::*;
#(
   parameter int ROWS    = 4,
   parameter int COLUMNS = 4
) (
   input  logic                 scanner_enabled,
   input  logic [KEY_SLOTS-1:0] keys_pressed,
   output logic [KEY_W-1:0]     raw_key
);

   // Keys beyond the matrix or beyond the snapshot are never seen.
   localparam int KEY_COUNT = (ROWS * COLUMNS < KEY_SLOTS) ? ROWS * COLUMNS : KEY_SLOTS;

   always_comb begin
      raw_key = NO_KEY;
      // scan downwards so the lowest pressed index is the last to win
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
         if (scanner_enabled && keys_pressed[i] && (i < KEY_COUNT)) begin
            raw_key = KEY_W'(i);
         end
      end
   end

endmodule

// File: sv/kpd_debounce.sv
// ----------------------------------------------------------------------------
// Keypad debounce and report latch
// Tracks reading changes against the poll time and reports a stable key once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_keypad_debounce_latch_defines.svh"

module kpd_debounce
   import kpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [KEY_W-1:0]      raw_key,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic [DEBOUNCE_W-1:0] debounce_ms,
   output logic [CHAR_W-1:0]     key_char
);

   logic [KEY_W-1:0]  last_seen_key_ff, last_seen_key_in;
   logic [KEY_W-1:0]  reported_key_ff, reported_key_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;

   logic              changed;
   logic              settling;
   logic              fresh_press;
   logic [TIME_W-1:0] elapsed;

   assign changed     = (raw_key != last_seen_key_ff);
   // wrapping subtraction copes with the millisecond counter rolling over
   assign elapsed     = now_ms - change_time_ff;
   assign settling    = (elapsed < {{(TIME_W - DEBOUNCE_W){1'b0}}, debounce_ms});
   assign fresh_press = !changed && !settling && (raw_key != NO_KEY)
                        && (raw_key != reported_key_ff);
   assign key_char    = fresh_press ? key_ascii(raw_key[3:0]) : NO_CHAR;

   always_comb begin
      last_seen_key_in = last_seen_key_ff;
      reported_key_in  = reported_key_ff;
      change_time_in   = change_time_ff;
      if (step) begin
         if (changed) begin
            // restart the timer on any new reading
            last_seen_key_in = raw_key;
            change_time_in   = now_ms;
         end else if (!settling) begin
            if (raw_key == NO_KEY) begin
               reported_key_in = NO_KEY;
            end else begin
               reported_key_in = raw_key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seen_key_ff <= NO_KEY;
         reported_key_ff  <= NO_KEY;
         change_time_ff   <= '0;
      end else begin
         last_seen_key_ff <= last_seen_key_in;
         reported_key_ff  <= reported_key_in;
         change_time_ff   <= change_time_in;
      end
   end

   `KPD_ASSERT(a_report_latches, clock, reset, (step && key_char != NO_CHAR) |=> (reported_key_ff == $past(raw_key)), "reported key not latched after a report")
   `KPD_ASSERT(a_change_restarts, clock, reset, (step && changed) |=> (last_seen_key_ff == $past(raw_key) && change_time_ff == $past(now_ms)), "reading change did not restart the timer")
   `KPD_ASSERT(a_idle_holds, clock, reset, !step |=> ($stable(last_seen_key_ff) && $stable(reported_key_ff) && $stable(change_time_ff)), "debounce state moved without a request")

endmodule

// File: dv/tb_matrix_keypad_debounce_latch.sv
// ----------------------------------------------------------------------------
// Matrix keypad debounce latch testbench
// Sends keypad polls through the request channel, keeps a cycle-free model of
// the debounce and latch behaviour, and checks each response against it.
// Directed polls cover priority, timer wrap, debounce limits and the
// disabled scanner. Random typing with bounces, noise and time jumps then
// runs under several register settings, with bursts of idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix_keypad_debounce_latch;
   import kpd_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int PAD_ROWS      = 4;
   localparam int PAD_COLUMNS   = 4;
   localparam int DRAIN_CYCLES  = 4;
   localparam int STALL_LIMIT   = 1000;

   // Indexes that no register answers to
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [KEY_SLOTS-1:0]   req_keys_pressed = '0;
   logic [TIME_W-1:0]      req_now_ms       = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [CHAR_W-1:0]      rsp_key_char;

   // Model of the block
   logic                   model_enabled  = 1'b0;
   logic [DEBOUNCE_W-1:0]  model_debounce = DEBOUNCE_RESET;
   logic [KEY_W-1:0]       seen_key       = NO_KEY;
   logic [KEY_W-1:0]       latched_key    = NO_KEY;
   logic [TIME_W-1:0]      changed_at     = '0;

   logic [CHAR_W-1:0]      expected_chars [$];

   bit                     send_gaps = 1'b1;
   bit                     rsp_gaps  = 1'b1;
   logic [TIME_W-1:0]      poll_clock = '0;
   int unsigned            polls_sent;
   int unsigned            polls_accepted;
   int unsigned            keys_reported;
   int unsigned            settings_tried;
   int unsigned            error_count;
   int unsigned            quiet_cycles;

   matrix_keypad_debounce_latch i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_keys_pressed (req_keys_pressed),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_char     (rsp_key_char)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic [KEY_W-1:0] lowest_key(input logic [KEY_SLOTS-1:0] keys);
      int idx;
      for (int r = 0; r < PAD_ROWS; r++) begin
         for (int c = 0; c < PAD_COLUMNS; c++) begin
            idx = r * PAD_COLUMNS + c;
            if (idx < KEY_SLOTS && keys[idx]) begin
               return KEY_W'(idx);
            end
         end
      end
      return NO_KEY;
   endfunction

   function automatic logic [7:0] pad_legend(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "D";
         4'd1:    ch = "C";
         4'd2:    ch = "B";
         4'd3:    ch = "A";
         4'd4:    ch = "#";
         4'd5:    ch = "9";
         4'd6:    ch = "6";
         4'd7:    ch = "3";
         4'd8:    ch = "0";
         4'd9:    ch = "8";
         4'd10:   ch = "5";
         4'd11:   ch = "2";
         4'd12:   ch = "*";
         4'd13:   ch = "7";
         4'd14:   ch = "4";
         default: ch = "1";
      endcase
      return ch;
   endfunction

   // Advance the model by one poll and return the character it reports
   function automatic logic [CHAR_W-1:0] predict_key_char(input logic [KEY_SLOTS-1:0] keys,
                                                         input logic [TIME_W-1:0] now);
      logic [KEY_W-1:0]  reading;
      logic [TIME_W-1:0] elapsed;
      logic [7:0]        ch;
      reading = model_enabled ? lowest_key(keys) : NO_KEY;
      if (reading != seen_key) begin
         seen_key   = reading;
         changed_at = now;
         return NO_CHAR;
      end
      elapsed = now - changed_at;
      if (elapsed < {{(TIME_W - DEBOUNCE_W){1'b0}}, model_debounce}) begin
         return NO_CHAR;
      end
      if (reading == NO_KEY) begin
         latched_key = NO_KEY;
         return NO_CHAR;
      end
      if (reading == latched_key) begin
         return NO_CHAR;
      end
      latched_key = reading;
      ch = pad_legend(reading[3:0]);
      return ch[CHAR_W-1:0];
   endfunction

   // Snoop writes, predict requests, check responses, watch for a hang
   always @(posedge clock) begin : scoreboard
      logic [CHAR_W-1:0] want;
      bit                progress;
      progress = 1'b0;
      if (!reset) begin
         if (csr_write_enable) begin
            progress = 1'b1;
            case (csr_index)
               CSR_SCANNER_ENABLED: model_enabled  = csr_write_data[0];
               CSR_DEBOUNCE_MS:     model_debounce = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            progress = 1'b1;
            expected_chars.push_back(predict_key_char(req_keys_pressed, req_now_ms));
            polls_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (expected_chars.size() == 0) begin
               $error("key_char: response with none expected, got 0x%02h", rsp_key_char);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (want != NO_CHAR) begin
                  keys_reported++;
               end
               if (rsp_key_char !== want) begin
                  $error("key_char mismatch: expected 0x%02h, got 0x%02h", want, rsp_key_char);
                  error_count++;
               end
            end
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Response side back-pressure: free stretches broken by stall bursts
   initial begin : rsp_backpressure
      int unsigned n;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(100, 300)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
         if (rsp_gaps) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 17);
            do begin
               @(posedge clock);
               n--;
            end while (n != 0 && rsp_gaps);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one poll and hold it until the block takes it
   task automatic send_poll(input logic [KEY_SLOTS-1:0] keys, input logic [TIME_W-1:0] now);
      if (send_gaps && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_keys_pressed <= keys;
      req_now_ms       <= now;
      polls_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic poll_after(input logic [KEY_SLOTS-1:0] keys, input int unsigned step);
      poll_clock = poll_clock + step;
      send_poll(keys, poll_clock);
   endtask

   // Hold off requests until every response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input bit enabled, input logic [DEBOUNCE_W-1:0] debounce);
      logic [CSR_DATA_W-1:0] junk;
      drain_responses();
      junk = CSR_DATA_W'($urandom);
      // only bit 0 of the enable counts
      write_csr(CSR_SCANNER_ENABLED, {junk[CSR_DATA_W-1:1], enabled});
      write_csr(CSR_DEBOUNCE_MS, debounce);
      settings_tried++;
   endtask

   task automatic test_disabled_after_reset();
      // scanner is off out of reset, spare indexes must not switch it on
      drain_responses();
      write_csr(CSR_SPARE_2, 16'hFFFF);
      write_csr(CSR_SPARE_3, 16'h0000);
      send_poll(16'hFFFF, 32'd0);
      send_poll(16'hFFFF, 32'd30);
      send_poll(16'h0001, 32'd60);
      send_poll(16'h0001, 32'd90);
   endtask

   task automatic test_reset_debounce();
      drain_responses();
      write_csr(CSR_SCANNER_ENABLED, 16'h0001);
      send_poll(16'h0020, 32'd100);
      send_poll(16'h0020, 32'd119);
      send_poll(16'h0020, 32'd120);
      send_poll(16'h0000, 32'd121);
      send_poll(16'h0000, 32'd141);
   endtask

   task automatic test_key_priority();
      configure(1'b1, 16'd0);
      send_poll(16'hFFFF, 32'd200);
      send_poll(16'hFFFF, 32'd201);
      send_poll(16'h8000, 32'd202);
      send_poll(16'h8000, 32'd203);
      send_poll(16'h8400, 32'd204);
      send_poll(16'h8400, 32'd205);
      send_poll(16'h8400, 32'd206);
   endtask

   task automatic test_timer_wrap();
      configure(1'b1, 16'd20);
      send_poll(16'h0010, 32'hFFFF_FFF8);
      send_poll(16'h0010, 32'h0000_0004);
      send_poll(16'h0010, 32'h0000_000C);
   endtask

   task automatic test_disable_clears_latch();
      configure(1'b1, 16'd0);
      send_poll(16'h0100, 32'd10);
      send_poll(16'h0100, 32'd11);
      configure(1'b0, 16'd0);
      send_poll(16'h0100, 32'd12);
      send_poll(16'h0100, 32'd13);
      configure(1'b1, 16'd0);
      send_poll(16'h0100, 32'd14);
      send_poll(16'h0100, 32'd15);
   endtask

   task automatic test_longest_debounce();
      configure(1'b1, 16'hFFFF);
      send_poll(16'h0002, 32'd0);
      send_poll(16'h0002, 32'd65534);
      send_poll(16'h0002, 32'd65535);
   endtask

   // Keystrokes with bounce, hold and release, mixed with noise and jumps
   task automatic test_random_typing(input int unsigned polls, input int unsigned step_max);
      int unsigned      start;
      int unsigned      kind;
      logic [KEY_SLOTS-1:0] pattern;
      logic [KEY_SLOTS-1:0] noise;
      start = polls_sent;
      while (polls_sent - start < polls) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            pattern = 16'h0001 << $urandom_range(0, 15);
            if ($urandom_range(0, 4) == 0) begin
               pattern = pattern | (16'h0001 << $urandom_range(0, 15));
            end
            repeat ($urandom_range(0, 3)) begin
               noise = KEY_SLOTS'($urandom);
               poll_after(noise, $urandom_range(0, 2));
            end
            repeat ($urandom_range(1, 6)) poll_after(pattern, $urandom_range(0, step_max));
            repeat ($urandom_range(1, 4)) poll_after(16'h0000, $urandom_range(0, step_max));
         end else if (kind < 9) begin
            repeat ($urandom_range(1, 8)) begin
               noise = KEY_SLOTS'($urandom);
               poll_after(noise, $urandom_range(0, 2 * step_max));
            end
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               poll_clock = $urandom;
            end else begin
               poll_clock = 32'hFFFF_FFFF - $urandom_range(0, step_max);
            end
            noise = KEY_SLOTS'($urandom);
            poll_after(noise, 0);
         end
      end
   endtask

   initial begin : stimulus
      logic [DEBOUNCE_W-1:0] debounce;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_after_reset();
      test_reset_debounce();
      test_key_priority();
      test_timer_wrap();
      test_disable_clears_latch();
      test_longest_debounce();

      configure(1'b1, 16'd0);
      test_random_typing(240, 2);
      configure(1'b1, 16'd1);
      test_random_typing(180, 2);
      configure(1'b1, 16'd20);
      test_random_typing(240, 12);
      debounce = DEBOUNCE_W'($urandom_range(2, 200));
      configure(1'b1, debounce);
      test_random_typing(220, debounce / 2 + 1);
      configure(1'b0, 16'd5);
      test_random_typing(100, 4);
      configure(1'b1, 16'hFFFF);
      test_random_typing(140, 32768);
      debounce = DEBOUNCE_W'($urandom);
      configure(1'b1, debounce);
      test_random_typing(200, debounce / 2 + 1);

      // drop all idling for the closing stretch
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      configure(1'b1, 16'd3);
      test_random_typing(240, 3);

      drain_responses();
      $display("Covered %0d polls, %0d key reports, %0d register settings;",
               polls_accepted, keys_reported, settings_tried);
      $display("directed priority, timer wrap, debounce limits and disabled scanner.");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/kpd_pkg.sv
sv/kpd_encode.sv
sv/kpd_debounce.sv
sv/matrix_keypad_debounce_latch.sv
dv/tb_matrix_keypad_debounce_latch.sv
